>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks, the top level.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sida_pkg.sv
// Shared constants and controller/datapath interface types for the
// signed integer to decimal ASCII converter. Depends on nothing.
package sida_pkg;

   // Digit storage: a 32-bit magnitude has at most ten decimal digits.
   localparam int unsigned DigitCount    = 10;
   localparam int unsigned DigitIdxWidth = $clog2(DigitCount);
   localparam int unsigned CountWidth    = $clog2(DigitCount + 1);

   // Division by ten through a reciprocal: q = (n * Recip) >> RecipShift,
   // exact for every 32-bit unsigned n.
   localparam logic [31:0] Recip      = 32'hCCCC_CCCD;
   localparam int unsigned RecipShift = 35;
   localparam int unsigned QuotWidth  = 64 - RecipShift;

   // ASCII codes.
   localparam logic [7:0] CharZero  = 8'd48;
   localparam logic [7:0] CharMinus = 8'd45;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new value and its magnitude
      logic mul;         // multiply the magnitude by the reciprocal
      logic div;         // finish one division step, store one digit
      logic emit_sign;   // load the minus sign into the output register
      logic emit_digit;  // load the next stored digit into the output register
   } sida_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic negative;    // the captured value is negative
      logic quot_zero;   // the quotient of the current step is zero
      logic last;        // the output register holds the final character
   } sida_status_type;

endpackage

>>> rtl/sida_dp.sv
// Datapath of the decimal converter: magnitude, reciprocal multiplier,
// digit store and output character register. Depends on sida_pkg.
module sida_dp import sida_pkg::*; (
   input  logic                   clock,
   input  logic signed [31:0]     value,
   input  sida_cmd_type           cmd,
   output sida_status_type        status,
   output logic [7:0]             out_char,
   output logic                   is_last
);

   logic [31:0]                 mag_ff;
   logic [31:0]                 mag_in;
   logic [63:0]                 prod_ff;
   logic                        neg_ff;
   logic [3:0]                  dig_ff [DigitCount];
   logic [CountWidth-1:0]       ndig_ff;
   logic [7:0]                  char_ff;
   logic                        last_ff;
   logic [QuotWidth-1:0]        quot;
   logic [31:0]                 quot_times_ten;
   logic [3:0]                  rem;
   logic [DigitIdxWidth-1:0]    rd_idx;

   // Two's complement magnitude; the minimum value maps to 2^31.
   assign mag_in = value[31] ? (~value + 32'd1) : value;

   // Quotient and remainder of the current division step.
   assign quot           = prod_ff[63:RecipShift];
   assign quot_times_ten = (32'(quot) << 3) + (32'(quot) << 1);
   assign rem            = mag_ff[3:0] - quot_times_ten[3:0];

   // Digits are stored least significant first, so the most significant
   // one sits one below the digit count.
   assign rd_idx = DigitIdxWidth'(ndig_ff - CountWidth'(1));

   // Magnitude, product and digit store.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= value[31];
         mag_ff  <= mag_in;
         ndig_ff <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= 64'(mag_ff) * 64'(Recip);
      end
      if (cmd.div) begin
         mag_ff                         <= 32'(quot);
         ndig_ff                        <= ndig_ff + CountWidth'(1);
         dig_ff[DigitIdxWidth'(ndig_ff)] <= rem;
      end
      if (cmd.emit_sign) begin
         char_ff <= CharMinus;
         last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         char_ff <= CharZero + {4'd0, dig_ff[rd_idx]};
         last_ff <= (ndig_ff == CountWidth'(1));
         ndig_ff <= ndig_ff - CountWidth'(1);
      end
   end

   assign status.negative  = neg_ff;
   assign status.quot_zero = (quot == '0);
   assign status.last      = last_ff;
   assign out_char         = char_ff;
   assign is_last          = last_ff;

endmodule

>>> rtl/sida_ctrl.sv
// Controller of the decimal converter: sequences the division steps and
// the character output handshake. Depends on sida_pkg.
module sida_ctrl import sida_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  sida_status_type status,
   output sida_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FIRST,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Next state and registered valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            state_in = status.quot_zero ? S_FIRST : S_MUL;
         end
         S_FIRST: begin
            state_in     = S_OUT;
            rsp_valid_in = 1'b1;
         end
         S_OUT: begin
            if (!rsp_stall && status.last) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath commands decoded from the state and the handshakes.
   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == S_IDLE) && req_valid;
      cmd.mul        = (state_ff == S_MUL);
      cmd.div        = (state_ff == S_DIV);
      cmd.emit_sign  = (state_ff == S_FIRST) && status.negative;
      cmd.emit_digit = ((state_ff == S_FIRST) && !status.negative) ||
                       ((state_ff == S_OUT) && !rsp_stall && !status.last);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
//
// The req channel takes one signed 32-bit value per item (req_valid,
// req_stall, req_value). The rsp channel returns its decimal text, one
// ASCII character per item (rsp_valid, rsp_stall, rsp_out_char,
// rsp_is_last): a minus sign first for a negative value, then the digits
// most significant first with no leading zeros. rsp_is_last marks the
// final character of each number.
// A value with D digits yields C characters: C = D, or D + 1 when negative.
// The division steps share one reciprocal multiplier; each step passes
// through S_MUL and S_DIV and stores one digit, then S_FIRST loads the
// first character. The output register then delivers one character per
// cycle while rsp is not stalled.
// The block holds one value at a time; req_stall stays high from
// acceptance until the last character is taken. A stall on rsp holds the
// current character in the output register. Synchronous reset returns the
// block to idle with no result pending; nothing is kept between values.
// Depends on sida_pkg, sida_ctrl, sida_dp and assert_macros.svh.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii import sida_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_is_last
);

   sida_cmd_type    cmd;
   sida_status_type status;
   logic            req_take;
   logic            last_take;
   logic            idle_ok;
   logic            char_ok;

   // Sequencing of the division steps and the output handshake.
   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, digit store and output character.
   sida_dp u_dp (
      .clock    (clock),
      .value    (req_value),
      .cmd      (cmd),
      .status   (status),
      .out_char (rsp_out_char),
      .is_last  (rsp_is_last)
   );

   // Handshake and character conditions used by the checks below.
   assign req_take  = req_valid && !req_stall;
   assign last_take = rsp_valid && !rsp_stall && rsp_is_last;
   assign idle_ok   = !req_stall && !rsp_valid;
   assign char_ok   = (rsp_out_char == CharMinus) ||
                      ((rsp_out_char >= CharZero) && (rsp_out_char <= (CharZero + 8'd9)));

   // Only one value is in flight, so no result shows while input is open.
   `ASSERT_SAME(a_one_in_flight, clock, reset, rsp_valid, req_stall, "result while input open")
   // An accepted value needs division steps before any character appears.
   `ASSERT_NEXT(a_no_early_rsp, clock, reset, req_take, !rsp_valid, "early result")
   // Every character is a minus sign or a decimal digit.
   `ASSERT_SAME(a_char_range, clock, reset, rsp_valid, char_ok, "bad character")
   // Handing over the last character reopens the input.
   `ASSERT_NEXT(a_reopen, clock, reset, last_take, idle_ok, "input not reopened")

endmodule
